// ===== rtl/core/efd_pkg.sv =====
// shared types, constants and functions of the escaped frame deframer
// no dependencies; compiled before every other file of the block
package efd_pkg;

    // frame layout and escape codes
    localparam logic [7:0] SYNC_BYTE0   = 8'h55;
    localparam logic [7:0] SYNC_BYTE1   = 8'hAA;
    localparam logic [7:0] ESC_BYTE     = 8'h7D;
    localparam logic [7:0] ESC_FLAG_SUB = 8'h5E;
    localparam logic [7:0] ESC_ESC_SUB  = 8'h5D;
    localparam logic [7:0] FLAG_BYTE    = 8'h7E;

    localparam int unsigned POS_W         = 17;
    localparam int unsigned LEN_W         = 16;
    localparam int unsigned MIN_FRAME_LEN = 6;
    localparam int unsigned REGION_START  = 6;
    localparam int unsigned HOLD_DEPTH    = 4;
    localparam int unsigned MAX_RESULTS   = 3;
    localparam int unsigned QUEUE_DEPTH   = 4;

    localparam logic [POS_W-1:0] POS_MAX  = {POS_W{1'b1}};
    localparam logic [31:0]      CRC_POLY = 32'hEDB88320;
    localparam logic [31:0]      CRC_INIT = 32'hFFFFFFFF;

    // result item kinds
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // frame status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BAD_SYNC = 2'd1;
    localparam logic [1:0] STATUS_BAD_LEN = 2'd2;
    localparam logic [1:0] STATUS_BAD_CRC = 2'd3;

    typedef struct packed {
        logic       item_kind;
        logic [7:0] data_byte;
        logic [1:0] frame_status;
        logic       run_last;
    } res_item_t;

    // all results caused by one accepted byte, in order
    typedef struct packed {
        res_item_t [MAX_RESULTS-1:0] item;
        logic [1:0]                  count;
    } res_bundle_t;

    // crc holdback and running crc, with the byte that leaves the holdback
    typedef struct packed {
        logic [HOLD_DEPTH-1:0][7:0] hb;
        logic [2:0]                 fill;
        logic [31:0]                crc;
        logic                       emit;
        logic [7:0]                 emit_byte;
    } hold_t;

    // holdback at the start of a frame
    localparam hold_t HOLD_CLEAR = '{hb: '0, fill: 3'd0, crc: CRC_INIT, emit: 1'b0,
                                     emit_byte: 8'h00};

    // reflected crc-32, one byte, unrolled over its eight bits
    function automatic logic [31:0] crc_byte(logic [31:0] crc_in, logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'h0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'h0);
        end
        return c;
    endfunction

    // push one unescaped byte; once four are held, the oldest leaves as data
    function automatic hold_t push_byte(hold_t s, logic [7:0] b);
        hold_t r;
        r           = s;
        r.emit      = 1'b0;
        r.emit_byte = 8'h00;
        if (s.fill[2])
        begin
            r.emit      = 1'b1;
            r.emit_byte = s.hb[0];
            r.crc       = crc_byte(s.crc, s.hb[0]);
            r.hb        = {b, s.hb[3], s.hb[2], s.hb[1]};
        end
        else
        begin
            r.hb[s.fill[1:0]] = b;
            r.fill            = s.fill + 3'd1;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/efd_channels.sv =====
// valid/ready channel interfaces of the escaped frame deframer
// no dependencies; compiled after efd_pkg
interface efd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       final_byte;

    modport source (output valid, output rx_byte, output final_byte, input ready);
    modport sink   (input valid, input rx_byte, input final_byte, output ready);
endinterface

interface efd_res_if;
    logic       valid;
    logic       ready;
    logic       item_kind;
    logic [7:0] data_byte;
    logic [1:0] frame_status;
    logic       run_last;

    modport source (output valid, output item_kind, output data_byte,
                    output frame_status, output run_last, input ready);
    modport sink   (input valid, input item_kind, input data_byte,
                    input frame_status, input run_last, output ready);
endinterface

// ===== rtl/core/escaped_frame_deframer_crc32.sv =====
// top level of the escaped frame deframer with crc-32 check
// depends on efd_pkg, efd_channels, efd_parser and efd_out_queue

// Takes a frame one byte per transaction (final_byte on its last byte) and
// returns unescaped data bytes followed by one status item per frame: ok, bad
// sync, bad length or crc mismatch. The last four unescaped bytes are kept back
// as the crc and never appear as data; on a bad status the consumer drops the
// data already received for that frame. A byte is taken every cycle while
// no more than one result is queued. Each byte gives zero to three results
// (an escape pair that falls through gives two data bytes, the last byte adds
// the status); these leave through a four-entry queue at one per cycle while
// the consumer is ready, so the input keeps one byte per cycle only while each
// byte gives at most one result and results are taken as fast as they arrive.
module escaped_frame_deframer_crc32 (
    input  logic      clk,
    input  logic      rst_n,
    efd_rx_if.sink    rx,
    efd_res_if.source res
);
    import efd_pkg::*;

    logic        take;
    logic        space;
    res_bundle_t bundle;

    assign rx.ready = space;
    assign take     = rx.valid && space;

    // parser: all the per-byte work, state updated on each transaction
    efd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .rx_byte    (rx.rx_byte),
        .final_byte (rx.final_byte),
        .bundle     (bundle)
    );

    // result queue between the parser and the consumer
    efd_out_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (take),
        .bundle (bundle),
        .space  (space),
        .res    (res)
    );

endmodule

// ===== rtl/core/efd_parser.sv =====
// frame parser: sync and length check, unescape, crc holdback and status
// depends on efd_pkg
module efd_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic [7:0]          rx_byte,
    input  logic                final_byte,
    output efd_pkg::res_bundle_t bundle
);
    import efd_pkg::*;

    logic [POS_W-1:0] pos_reg,  pos_next;
    logic [LEN_W-1:0] len_reg,  len_next;
    logic             esc_reg,  esc_next;
    logic             sync_reg, sync_next;
    hold_t            hold_reg, hold_next;

    logic [POS_W:0]   rend;
    logic [POS_W:0]   total;
    logic             in_region;
    logic             fresh;
    logic             push_a, push_b;
    logic [7:0]       byte_a;
    hold_t            hold_a, hold_b;
    logic [1:0]       status;
    logic [1:0]       n;

    // header fields and region bounds
    always_comb
    begin
        sync_next = sync_reg;
        if (pos_reg == POS_W'(0) && rx_byte != SYNC_BYTE0)
            sync_next = 1'b1;
        if (pos_reg == POS_W'(1) && rx_byte != SYNC_BYTE1)
            sync_next = 1'b1;

        len_next = len_reg;
        if (pos_reg == POS_W'(2))
            len_next = {8'h00, rx_byte};
        else if (pos_reg == POS_W'(3))
            len_next = {rx_byte, len_reg[7:0]};

        rend      = (POS_W+1)'(len_next) + (POS_W+1)'(2);
        total     = (POS_W+1)'(pos_reg) + (POS_W+1)'(1);
        in_region = !sync_next && pos_reg >= POS_W'(REGION_START)
                    && (POS_W+1)'(pos_reg) < rend;
    end

    // unescape: up to two bytes enter the holdback per received byte
    always_comb
    begin
        esc_next = esc_reg;
        push_a   = 1'b0;
        push_b   = 1'b0;
        byte_a   = ESC_BYTE;
        fresh    = 1'b1;
        if (in_region)
        begin
            if (esc_reg)
            begin
                esc_next = 1'b0;
                push_a   = 1'b1;
                if (rx_byte == ESC_FLAG_SUB)
                begin
                    byte_a = FLAG_BYTE;
                    fresh  = 1'b0;
                end
                else if (rx_byte == ESC_ESC_SUB)
                begin
                    byte_a = ESC_BYTE;
                    fresh  = 1'b0;
                end
            end
            if (fresh)
            begin
                if (rx_byte == ESC_BYTE && total < rend)
                    esc_next = 1'b1;
                else
                    push_b = 1'b1;
            end
        end
    end

    // holdback and crc, two pushes in series
    always_comb
    begin
        hold_a = push_a ? push_byte(hold_reg, byte_a) : hold_reg;
        if (!push_a)
            hold_a.emit = 1'b0;
        hold_b = push_b ? push_byte(hold_a, rx_byte) : hold_a;
        if (!push_b)
            hold_b.emit = 1'b0;
        hold_next = hold_b;
    end

    // end-of-frame status, in priority order
    always_comb
    begin
        priority if (total < (POS_W+1)'(MIN_FRAME_LEN))
            status = STATUS_BAD_LEN;
        else if (sync_next)
            status = STATUS_BAD_SYNC;
        else if (total != (POS_W+1)'(len_next) + (POS_W+1)'(4))
            status = STATUS_BAD_LEN;
        else if (len_next < LEN_W'(4) || !hold_b.fill[2])
            status = STATUS_BAD_LEN;
        else if (~hold_b.crc != hold_b.hb)
            status = STATUS_BAD_CRC;
        else
            status = STATUS_OK;
    end

    // pack the results of this byte in order and mark the last one
    always_comb
    begin
        bundle = '0;
        n      = 2'd0;
        if (hold_a.emit)
        begin
            bundle.item[n] = '{KIND_DATA, hold_a.emit_byte, STATUS_OK, 1'b0};
            n = n + 2'd1;
        end
        if (hold_b.emit)
        begin
            bundle.item[n] = '{KIND_DATA, hold_b.emit_byte, STATUS_OK, 1'b0};
            n = n + 2'd1;
        end
        if (final_byte)
        begin
            bundle.item[n] = '{KIND_STATUS, 8'h00, status, 1'b0};
            n = n + 2'd1;
        end
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            bundle.item[i].run_last = (2'(i) == n - 2'd1);
        end
        bundle.count = n;
    end

    // frame state; the last byte of a frame returns it to reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            len_reg       <= '0;
            esc_reg       <= 1'b0;
            sync_reg      <= 1'b0;
            hold_reg      <= HOLD_CLEAR;
        end
        else if (take)
        begin
            if (final_byte)
            begin
                pos_reg      <= '0;
                len_reg      <= '0;
                esc_reg      <= 1'b0;
                sync_reg     <= 1'b0;
                hold_reg     <= HOLD_CLEAR;
            end
            else
            begin
                pos_reg  <= (pos_reg < POS_MAX) ? pos_reg + POS_W'(1) : pos_reg;
                len_reg  <= len_next;
                esc_reg  <= esc_next;
                sync_reg <= sync_next;
                hold_reg <= hold_next;
            end
        end
    end

endmodule

// ===== rtl/core/efd_out_queue.sv =====
// four-entry result queue: takes up to three results a cycle, gives one
// while the consumer is ready; depends on efd_pkg and efd_channels
module efd_out_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  efd_pkg::res_bundle_t bundle,
    output logic                 space,
    efd_res_if.source            res
);
    import efd_pkg::*;

    res_item_t [QUEUE_DEPTH-1:0] q_reg, q_next;
    logic [2:0]                  cnt_reg, cnt_next;
    logic                        pop;
    logic [2:0]                  base;
    logic [2:0]                  off;

    assign pop   = res.valid && res.ready;
    assign space = (cnt_reg <= 3'd1);

    assign res.valid        = (cnt_reg != 3'd0);
    assign res.item_kind    = q_reg[0].item_kind;
    assign res.data_byte    = q_reg[0].data_byte;
    assign res.frame_status = q_reg[0].frame_status;
    assign res.run_last     = q_reg[0].run_last;

    // shift out the head, append new results behind what remains
    always_comb
    begin
        base = cnt_reg - {2'b00, pop};
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            off = 3'(i) - base;
            if (3'(i) < base)
            begin
                if (pop && i < QUEUE_DEPTH - 1)
                    q_next[i] = q_reg[(i + 1) % QUEUE_DEPTH];
                else
                    q_next[i] = q_reg[i];
            end
            else if (push && off < {1'b0, bundle.count})
                q_next[i] = bundle.item[off[1:0]];
            else
                q_next[i] = q_reg[i];
        end
        cnt_next = base + (push ? {1'b0, bundle.count} : 3'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

endmodule

// ===== verif/escaped_frame_deframer_crc32_tb.sv =====
// self-checking testbench for the escaped frame deframer with crc-32 check
// depends on efd_pkg, efd_channels and the escaped_frame_deframer_crc32 rtl
// directed rows first, then random frames
module escaped_frame_deframer_crc32_tb;
    import efd_pkg::*;

    localparam int RANDOM_BYTES     = 370;
    localparam int WATCHDOG_LIMIT   = 1000;
    localparam int DRAIN_CYCLES     = 20;
    localparam int REPORT_LIMIT     = 10;

    typedef enum logic [1:0] {CHK_MODEL, CHK_QUIET, CHK_STATUS} chk_mode_e;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       fin;
        chk_mode_e  mode;
        logic [1:0] status;
    } stim_row_t;

    // directed rows: status typed in where it is plain, otherwise predicted
    localparam stim_row_t DIRECTED_ROWS [28] = '{
        // a lone byte is too short whatever it holds
        '{8'hFF,        1'b1, CHK_STATUS, STATUS_BAD_LEN},
        // second sync byte wrong
        '{SYNC_BYTE0,   1'b0, CHK_QUIET,  STATUS_OK},
        '{8'h00,        1'b0, CHK_QUIET,  STATUS_OK},
        '{8'h00,        1'b0, CHK_QUIET,  STATUS_OK},
        '{8'h00,        1'b0, CHK_QUIET,  STATUS_OK},
        '{8'h00,        1'b0, CHK_QUIET,  STATUS_OK},
        '{8'h00,        1'b1, CHK_STATUS, STATUS_BAD_SYNC},
        // cut short inside the region with an escape pending
        '{SYNC_BYTE0,   1'b0, CHK_QUIET,  STATUS_OK},
        '{SYNC_BYTE1,   1'b0, CHK_QUIET,  STATUS_OK},
        '{8'h0A,        1'b0, CHK_QUIET,  STATUS_OK},
        '{8'h00,        1'b0, CHK_QUIET,  STATUS_OK},
        '{8'h00,        1'b0, CHK_QUIET,  STATUS_OK},
        '{8'hFF,        1'b0, CHK_QUIET,  STATUS_OK},
        '{ESC_BYTE,     1'b1, CHK_STATUS, STATUS_BAD_LEN},
        // flag and fall-through escapes, a lone escape closing the region, crc wrong
        '{SYNC_BYTE0,   1'b0, CHK_QUIET,  STATUS_OK},
        '{SYNC_BYTE1,   1'b0, CHK_QUIET,  STATUS_OK},
        '{8'h0A,        1'b0, CHK_QUIET,  STATUS_OK},
        '{8'h00,        1'b0, CHK_QUIET,  STATUS_OK},
        '{8'h00,        1'b0, CHK_QUIET,  STATUS_OK},
        '{8'hFF,        1'b0, CHK_QUIET,  STATUS_OK},
        '{ESC_BYTE,     1'b0, CHK_QUIET,  STATUS_OK},
        '{ESC_FLAG_SUB, 1'b0, CHK_QUIET,  STATUS_OK},
        '{ESC_BYTE,     1'b0, CHK_QUIET,  STATUS_OK},
        '{8'h41,        1'b0, CHK_QUIET,  STATUS_OK},
        '{ESC_ESC_SUB,  1'b0, CHK_QUIET,  STATUS_OK},
        '{ESC_BYTE,     1'b0, CHK_MODEL,  STATUS_OK},
        '{8'h00,        1'b0, CHK_QUIET,  STATUS_OK},
        '{8'hFF,        1'b1, CHK_MODEL,  STATUS_OK}
    };

    logic clk;
    logic rst_n;

    efd_rx_if  rx_ch ();
    efd_res_if res_ch ();

    escaped_frame_deframer_crc32 dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .res   (res_ch)
    );

    // deframer state as predicted
    logic [16:0] frame_pos;
    logic [15:0] decl_len;
    logic        esc_pend;
    logic [7:0]  hold_bytes [4];
    int          hold_n;
    logic [31:0] crc_acc;
    logic        sync_bad;

    res_item_t   step_items [$];
    res_item_t   expected_items [$];
    res_item_t   head_item;
    logic [7:0]  frame_bytes [$];

    bit          no_gaps;
    int          errors;
    int          idle_cycles;
    int          bytes_in;
    int          frames_sent;
    int          data_checked;
    int          status_seen [4];

    // clock
    always #5 clk = ~clk;

    function automatic void note_error(string msg);
        errors++;
        if (errors <= REPORT_LIMIT)
        begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
    endfunction

    // reflected crc-32, one bit of the byte at a time
    function automatic logic [31:0] crc32_next(logic [31:0] c, logic [7:0] b);
        for (int i = 0; i < 8; i++)
        begin
            if (c[0] ^ b[i])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    function automatic void frame_clear();
        frame_pos = '0;
        decl_len  = '0;
        esc_pend  = 1'b0;
        foreach (hold_bytes[i])
            hold_bytes[i] = 8'h00;
        hold_n    = 0;
        crc_acc   = CRC_INIT;
        sync_bad  = 1'b0;
    endfunction

    // unescaped byte into the crc holdback; the oldest leaves as data once four are held
    function automatic void hold_byte(logic [7:0] v);
        res_item_t it;
        if (hold_n >= HOLD_DEPTH)
        begin
            it = '{item_kind: KIND_DATA, data_byte: hold_bytes[0],
                   frame_status: STATUS_OK, run_last: 1'b0};
            step_items.push_back(it);
            crc_acc       = crc32_next(crc_acc, hold_bytes[0]);
            hold_bytes[0] = hold_bytes[1];
            hold_bytes[1] = hold_bytes[2];
            hold_bytes[2] = hold_bytes[3];
            hold_bytes[3] = v;
        end
        else
        begin
            hold_bytes[hold_n] = v;
            hold_n++;
        end
    endfunction

    // results caused by one received byte, left in step_items
    function automatic void deframe_byte(logic [7:0] b, logic fin);
        logic [16:0] p;
        logic [17:0] rend;
        logic [17:0] total;
        logic        fresh;
        logic [1:0]  st;
        logic [31:0] got;
        res_item_t   it;
        step_items = {};
        p = frame_pos;
        if (p == 17'd0 && b != SYNC_BYTE0)
            sync_bad = 1'b1;
        if (p == 17'd1 && b != SYNC_BYTE1)
            sync_bad = 1'b1;
        if (p == 17'd2)
            decl_len = {8'h00, b};
        if (p == 17'd3)
            decl_len[15:8] = b;
        rend = {2'b00, decl_len} + 18'd2;

        // escaped region
        if (!sync_bad && p >= REGION_START && {1'b0, p} < rend)
        begin
            fresh = 1'b1;
            if (esc_pend)
            begin
                esc_pend = 1'b0;
                if (b == ESC_FLAG_SUB)
                begin
                    hold_byte(FLAG_BYTE);
                    fresh = 1'b0;
                end
                else if (b == ESC_ESC_SUB)
                begin
                    hold_byte(ESC_BYTE);
                    fresh = 1'b0;
                end
                else
                    hold_byte(ESC_BYTE);
            end
            if (fresh)
            begin
                if (b == ESC_BYTE && {1'b0, p} + 18'd1 < rend)
                    esc_pend = 1'b1;
                else
                    hold_byte(b);
            end
        end

        if (frame_pos != POS_MAX)
            frame_pos = frame_pos + 17'd1;

        // end of frame status, by priority
        if (fin)
        begin
            total = {1'b0, p} + 18'd1;
            got   = {hold_bytes[3], hold_bytes[2], hold_bytes[1], hold_bytes[0]};
            if (total < MIN_FRAME_LEN)
                st = STATUS_BAD_LEN;
            else if (sync_bad)
                st = STATUS_BAD_SYNC;
            else if (total != {2'b00, decl_len} + 18'd4)
                st = STATUS_BAD_LEN;
            else if (decl_len < HOLD_DEPTH || hold_n < HOLD_DEPTH)
                st = STATUS_BAD_LEN;
            else if (~crc_acc == got)
                st = STATUS_OK;
            else
                st = STATUS_BAD_CRC;
            it = '{item_kind: KIND_STATUS, data_byte: 8'h00, frame_status: st, run_last: 1'b0};
            step_items.push_back(it);
            frame_clear();
        end

        if (step_items.size() > 0)
        begin
            it = step_items.pop_back();
            it.run_last = 1'b1;
            step_items.push_back(it);
        end
    endfunction

    // one byte transaction, with random gaps before it
    task automatic send_byte(input logic [7:0] b, input logic fin, input chk_mode_e mode,
                             input logic [1:0] st);
        res_item_t it;
        while (!no_gaps && $urandom_range(0, 99) < 24)
        begin
            rx_ch.valid <= 1'b0;
            @(negedge clk);
        end
        rx_ch.valid      <= 1'b1;
        rx_ch.rx_byte    <= b;
        rx_ch.final_byte <= fin;
        @(posedge clk);
        while (!rx_ch.ready)
            @(posedge clk);
        deframe_byte(b, fin);
        case (mode)
            CHK_MODEL:
            begin
                foreach (step_items[i])
                    expected_items.push_back(step_items[i]);
            end
            CHK_STATUS:
            begin
                it = '{item_kind: KIND_STATUS, data_byte: 8'h00, frame_status: st,
                       run_last: 1'b1};
                expected_items.push_back(it);
            end
            default:
            begin
            end
        endcase
        bytes_in++;
        @(negedge clk);
    endtask

    // sender holds off until every predicted result has come back
    task automatic wait_drained();
        rx_ch.valid <= 1'b0;
        @(negedge clk);
        while (expected_items.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return ESC_BYTE;
        else if (r < 18)
            return FLAG_BYTE;
        else if (r < 23)
            return ESC_FLAG_SUB;
        else if (r < 28)
            return ESC_ESC_SUB;
        return 8'($urandom_range(0, 255));
    endfunction

    // well-formed frame with a random payload and its crc, escaped at random
    task automatic make_good_frame(input int plen);
        logic [7:0]  raw [$];
        logic [7:0]  region [$];
        logic [31:0] fcs;
        logic [15:0] len_f;
        logic [7:0]  v;
        logic        lone_ok;
        fcs = CRC_INIT;
        for (int k = 0; k < plen; k++)
        begin
            v = pick_byte();
            raw.push_back(v);
            fcs = crc32_next(fcs, v);
        end
        fcs = ~fcs;
        raw.push_back(fcs[7:0]);
        raw.push_back(fcs[15:8]);
        raw.push_back(fcs[23:16]);
        raw.push_back(fcs[31:24]);

        // escape; a lone escape byte only where the next byte cannot pair with it
        for (int k = 0; k < raw.size(); k++)
        begin
            v = raw[k];
            if (v == FLAG_BYTE && $urandom_range(0, 1) == 1)
            begin
                region.push_back(ESC_BYTE);
                region.push_back(ESC_FLAG_SUB);
            end
            else if (v == ESC_BYTE)
            begin
                lone_ok = (k == raw.size() - 1) ||
                          (raw[k+1] != ESC_FLAG_SUB && raw[k+1] != ESC_ESC_SUB);
                region.push_back(ESC_BYTE);
                if (!(lone_ok && $urandom_range(0, 1) == 1))
                    region.push_back(ESC_ESC_SUB);
            end
            else
                region.push_back(v);
        end

        len_f = 16'(region.size() + 4);
        frame_bytes = {};
        frame_bytes.push_back(SYNC_BYTE0);
        frame_bytes.push_back(SYNC_BYTE1);
        frame_bytes.push_back(len_f[7:0]);
        frame_bytes.push_back(len_f[15:8]);
        frame_bytes.push_back(8'($urandom_range(0, 255)));
        frame_bytes.push_back(8'($urandom_range(0, 255)));
        foreach (region[i])
            frame_bytes.push_back(region[i]);
        frame_bytes.push_back(8'($urandom_range(0, 255)));
        frame_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    // mostly good frames, the rest broken in one way or another
    task automatic make_random_frame();
        int          sel;
        int          plen;
        int          idx;
        int          cut;
        logic [15:0] len_f;
        sel  = $urandom_range(0, 99);
        plen = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
        if (sel < 88)
            make_good_frame(plen);
        if (sel < 62)
        begin
            // occasional bit error in the region
            if ($urandom_range(0, 6) == 0)
            begin
                idx = 6 + $urandom_range(0, frame_bytes.size() - 9);
                frame_bytes[idx] = frame_bytes[idx] ^ (8'h01 << $urandom_range(0, 7));
            end
        end
        else if (sel < 70)
        begin
            // declared length off by a little, or a wild high byte
            len_f = {frame_bytes[3], frame_bytes[2]};
            if ($urandom_range(0, 2) == 0)
                len_f[15:8] = 8'($urandom_range(1, 255));
            else if ($urandom_range(0, 1) == 1)
                len_f = len_f + 16'($urandom_range(1, 3));
            else
                len_f = len_f - 16'($urandom_range(1, 3));
            frame_bytes[2] = len_f[7:0];
            frame_bytes[3] = len_f[15:8];
        end
        else if (sel < 82)
        begin
            // frame cut short or running past its end
            if ($urandom_range(0, 1) == 1)
            begin
                cut = $urandom_range(1, frame_bytes.size() - 1);
                while (frame_bytes.size() > cut)
                    void'(frame_bytes.pop_back());
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    frame_bytes.push_back(8'($urandom_range(0, 255)));
            end
        end
        else if (sel < 88)
        begin
            idx = $urandom_range(0, 1);
            frame_bytes[idx] = frame_bytes[idx] ^ 8'($urandom_range(1, 255));
        end
        else if (sel < 94)
        begin
            // declared length below the holdback size
            len_f = 16'($urandom_range(0, 3));
            frame_bytes = {};
            frame_bytes.push_back(SYNC_BYTE0);
            frame_bytes.push_back(SYNC_BYTE1);
            frame_bytes.push_back(len_f[7:0]);
            frame_bytes.push_back(8'h00);
            while (frame_bytes.size() < len_f + 4)
                frame_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            // line noise, often shorter than the smallest frame
            frame_bytes = {};
            repeat ($urandom_range(1, 12))
                frame_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // receiver stalls at random
    always @(negedge clk)
    begin
        res_ch.ready <= no_gaps || ($urandom_range(0, 99) >= 24);
    end

    // result checking against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_items.size() == 0)
                note_error($sformatf(
                    "result with nothing predicted: kind %0d data %02h status %0d last %0d",
                    res_ch.item_kind, res_ch.data_byte, res_ch.frame_status,
                    res_ch.run_last));
            else
            begin
                head_item = expected_items.pop_front();
                if (res_ch.item_kind !== head_item.item_kind ||
                    res_ch.data_byte !== head_item.data_byte ||
                    res_ch.frame_status !== head_item.frame_status ||
                    res_ch.run_last !== head_item.run_last)
                    note_error($sformatf(
                        {"expected kind %0d data %02h status %0d last %0d, ",
                         "got kind %0d data %02h status %0d last %0d"},
                        head_item.item_kind, head_item.data_byte,
                        head_item.frame_status, head_item.run_last,
                        res_ch.item_kind, res_ch.data_byte,
                        res_ch.frame_status, res_ch.run_last));
                if (head_item.item_kind == KIND_STATUS)
                    status_seen[head_item.frame_status]++;
                else
                    data_checked++;
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                     idle_cycles, expected_items.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        int rand_bytes;
        clk              = 1'b0;
        rst_n            = 1'b0;
        rx_ch.valid      = 1'b0;
        rx_ch.rx_byte    = 8'h00;
        rx_ch.final_byte = 1'b0;
        res_ch.ready     = 1'b0;
        no_gaps          = 1'b0;
        errors           = 0;
        idle_cycles      = 0;
        bytes_in         = 0;
        frames_sent      = 0;
        data_checked     = 0;
        rand_bytes       = 0;
        foreach (status_seen[i])
            status_seen[i] = 0;
        frame_clear();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed rows
        foreach (DIRECTED_ROWS[i])
        begin
            send_byte(DIRECTED_ROWS[i].rx_byte, DIRECTED_ROWS[i].fin, DIRECTED_ROWS[i].mode,
                      DIRECTED_ROWS[i].status);
            if (DIRECTED_ROWS[i].fin)
                frames_sent++;
        end
        wait_drained();

        // random frames, with a stretch free of gaps on both sides
        while (rand_bytes < RANDOM_BYTES)
        begin
            no_gaps = (rand_bytes >= 150 && rand_bytes < 260);
            make_random_frame();
            foreach (frame_bytes[i])
                send_byte(frame_bytes[i], i == frame_bytes.size() - 1, CHK_MODEL, STATUS_OK);
            rand_bytes += frame_bytes.size();
            frames_sent++;
            if ($urandom_range(0, 4) == 0)
                wait_drained();
        end
        no_gaps = 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_items.size() != 0)
            note_error($sformatf("%0d predicted results never arrived", expected_items.size()));

        $display("covered %0d frames, %0d bytes in, good and broken, with stalls on both sides",
                 frames_sent, bytes_in);
        $display("checked %0d data bytes; statuses ok %0d, sync %0d, length %0d, crc %0d",
                 data_checked, status_seen[STATUS_OK], status_seen[STATUS_BAD_SYNC],
                 status_seen[STATUS_BAD_LEN], status_seen[STATUS_BAD_CRC]);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
